[rtl/core/rqir_pkg.sv]
// Shared types and codes for the ring queue with indexed removal.
`default_nettype none

package rqir_pkg;

    // Fixed widths of the item fields.
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 16;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // Default configuration of the queue.
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_ENTRY_WIDTH = 16;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EXTRACT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value_in;
        logic [SLOT_W-1:0]   slot_index;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0]  value_out;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

endpackage

`default_nettype wire

[rtl/core/rqir_store.sv]
// Entry memory of the ring queue: one write port and one registered read port.
`default_nettype none

module rqir_store #(
    parameter int QUEUE_DEPTH = rqir_pkg::DEF_QUEUE_DEPTH,
    parameter int ENTRY_WIDTH = rqir_pkg::DEF_ENTRY_WIDTH,
    localparam int PW = $clog2(QUEUE_DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_wr_en,
    input  wire logic [PW-1:0]          i_wr_addr,
    input  wire logic [ENTRY_WIDTH-1:0] i_wr_data,
    input  wire logic                   i_rd_en,
    input  wire logic [PW-1:0]          i_rd_addr,
    output logic      [ENTRY_WIDTH-1:0] o_rd_data
);

    logic [ENTRY_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [ENTRY_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[rtl/core/rqir_step.sv]
// Shared slot stepper: circular increment of a slot and a compare of the result.
`default_nettype none

module rqir_step #(
    parameter int QUEUE_DEPTH = rqir_pkg::DEF_QUEUE_DEPTH,
    localparam int PW = $clog2(QUEUE_DEPTH)
) (
    input  wire logic [PW-1:0] i_slot,
    input  wire logic [PW-1:0] i_ref,
    output logic      [PW-1:0] o_slot,
    output logic               o_match
);

    // Wrap to slot zero after the last physical slot.
    always_comb begin
        if (i_slot == PW'(QUEUE_DEPTH - 1)) begin
            o_slot = '0;
        end else begin
            o_slot = i_slot + PW'(1);
        end
        o_match = (o_slot == i_ref);
    end

endmodule

`default_nettype wire

[rtl/core/ring_queue_with_indexed_removal.sv]
// Top level of the ring queue with indexed removal: sequencer, counters and result register.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+----------------------------
//   input   | in        | i_in_valid / o_in_stall | i_in_item  (rqir_pkg::t_in_item)
//   output  | out       | o_out_valid/ i_out_stall| o_out_item (rqir_pkg::t_out_item)
//
// Sequence: an insert, a rejected action or an unused action code passes EVAL and then DONE
// after acceptance; an extract or a removal of the head slot passes EVAL, POP and DONE.
// A removal inside the live region passes EVAL, TAKE, SHIFT once for every live entry behind
// the removed slot plus once more, and DONE; the one read port of the entry memory,
// shared with the write of the previous entry, moves one entry per cycle.
// Reset empties the queue by clearing head, tail and count; the entry memory is not cleared.
// The result sits in an output register, so a new item is taken while a result still waits;
// a stalled result only holds back the end of the following item.
`default_nettype none

module ring_queue_with_indexed_removal #(
    parameter int QUEUE_DEPTH = rqir_pkg::DEF_QUEUE_DEPTH,
    parameter int ENTRY_WIDTH = rqir_pkg::DEF_ENTRY_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire rqir_pkg::t_in_item   i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output rqir_pkg::t_out_item       o_out_item
);

    // Slot pointer and count widths follow from the depth.
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an item
    localparam logic [2:0] S_EVAL  = 3'd1;  // decide the action, start the memory access
    localparam logic [2:0] S_POP   = 3'd2;  // head entry arrives from memory
    localparam logic [2:0] S_TAKE  = 3'd3;  // removed entry arrives from memory
    localparam logic [2:0] S_SHIFT = 3'd4;  // close the gap one entry per cycle
    localparam logic [2:0] S_DONE  = 3'd5;  // hand the result to the output register

    logic [2:0]               r_state, n_state;
    logic [PW-1:0]            r_head, n_head;
    logic [PW-1:0]            r_tail, n_tail;
    logic [CW-1:0]            r_count, n_count;
    rqir_pkg::t_in_item       r_item, n_item;
    logic [PW-1:0]            r_cur, n_cur;
    logic [PW-1:0]            r_wr_slot, n_wr_slot;
    logic                     r_pend, n_pend;
    logic [rqir_pkg::VALUE_W-1:0]  r_res_value, n_res_value;
    logic [rqir_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                     r_out_valid, n_out_valid;
    rqir_pkg::t_out_item      r_out_item, n_out_item;

    // Memory and stepper connections.
    logic                   w_wr_en;
    logic [PW-1:0]          w_wr_addr;
    logic [ENTRY_WIDTH-1:0] w_wr_data;
    logic                   w_rd_en;
    logic [PW-1:0]          w_rd_addr;
    logic [ENTRY_WIDTH-1:0] w_rd_data;
    logic [PW-1:0]          w_step_in;
    logic [PW-1:0]          w_step_out;
    logic                   w_step_match;

    // Slot checks for a removal.
    logic          w_slot_bad;
    logic [PW-1:0] w_slot;
    logic [PW:0]   w_diff;
    logic [PW-1:0] w_dist;
    logic          w_full;
    logic          w_empty;
    logic          w_out_free;

    rqir_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // One stepper serves the tail advance on insert, the head advance on pop and
    // the walk toward the tail while entries are shifted back.
    rqir_step #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_step (
        .i_slot  (w_step_in),
        .i_ref   (r_tail),
        .o_slot  (w_step_out),
        .o_match (w_step_match)
    );

    always_comb begin
        unique case (r_state)
            S_EVAL:  w_step_in = r_tail;
            S_POP:   w_step_in = r_head;
            default: w_step_in = r_cur;
        endcase
    end

    // A slot is occupied when its circular distance from the head is below the count.
    assign w_slot_bad = ({1'b0, r_item.slot_index} >= (rqir_pkg::SLOT_W + 1)'(QUEUE_DEPTH));
    assign w_slot     = r_item.slot_index[PW-1:0];
    assign w_diff     = {1'b0, w_slot} - {1'b0, r_head};
    assign w_dist     = w_diff[PW] ? PW'(w_diff + (PW + 1)'(QUEUE_DEPTH)) : w_diff[PW-1:0];
    assign w_full     = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_item       = r_item;
        n_cur        = r_cur;
        n_wr_slot    = r_wr_slot;
        n_pend       = r_pend;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_tail;
        w_wr_data    = ENTRY_WIDTH'(r_item.value_in);
        w_rd_en      = 1'b0;
        w_rd_addr    = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_res_value  = '0;
                n_res_status = rqir_pkg::ST_OK;
                n_state      = S_DONE;
                case (r_item.action)
                    rqir_pkg::ACT_INSERT: begin
                        if (w_full) begin
                            n_res_status = rqir_pkg::ST_FULL;
                        end else begin
                            w_wr_en = 1'b1;
                            n_tail  = w_step_out;
                            n_count = r_count + CW'(1);
                        end
                    end
                    rqir_pkg::ACT_EXTRACT: begin
                        if (w_empty) begin
                            n_res_status = rqir_pkg::ST_EMPTY;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_POP;
                        end
                    end
                    rqir_pkg::ACT_REMOVE: begin
                        if (w_empty) begin
                            n_res_status = rqir_pkg::ST_EMPTY;
                        end else if (w_slot_bad || (CW'(w_dist) >= r_count)) begin
                            n_res_status = rqir_pkg::ST_BAD_SLOT;
                        end else if (w_slot == r_head) begin
                            // Removing the head is an ordinary pop.
                            w_rd_en = 1'b1;
                            n_state = S_POP;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_slot;
                            n_cur     = w_slot;
                            n_state   = S_TAKE;
                        end
                    end
                    default: begin
                        n_res_status = rqir_pkg::ST_BAD_SLOT;
                    end
                endcase
            end
            S_POP: begin
                n_res_value = rqir_pkg::VALUE_W'(w_rd_data);
                n_head      = w_step_out;
                n_count     = r_count - CW'(1);
                n_state     = S_DONE;
            end
            S_TAKE: begin
                n_res_value = rqir_pkg::VALUE_W'(w_rd_data);
                n_pend      = 1'b0;
                n_state     = S_SHIFT;
            end
            S_SHIFT: begin
                // The entry read last cycle lands one slot behind where it was.
                w_wr_en   = r_pend;
                w_wr_addr = r_wr_slot;
                w_wr_data = w_rd_data;
                if (w_step_match) begin
                    // The walk stops on the last live slot, which becomes the new tail.
                    n_tail  = r_cur;
                    n_count = r_count - CW'(1);
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_step_out;
                    n_wr_slot = r_cur;
                    n_cur     = w_step_out;
                    n_pend    = 1'b1;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_item.value_out = r_res_value;
                    n_out_item.status    = r_res_status;
                    n_out_item.occupancy = rqir_pkg::OCC_W'(r_count);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_cur        <= n_cur;
        r_wr_slot    <= n_wr_slot;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_item   <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // The count never exceeds the number of physical slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // Between items the tail sits count slots past the head.
    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
            ((int'(r_head) + int'(r_count) == int'(r_tail)) ||
             (int'(r_head) + int'(r_count) == int'(r_tail) + QUEUE_DEPTH)))
        else $error("head, tail and count disagree");

    // A dropped insert is only reported on a full queue.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == rqir_pkg::ST_FULL)) |->
            (o_out_item.occupancy == rqir_pkg::OCC_W'(QUEUE_DEPTH)))
        else $error("full status with a queue that is not full");

    // A shift only runs for a slot behind the head, so two entries at least are live.
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count > CW'(1)))
        else $error("shift with fewer than two live entries");

    // The result register is loaded only when leaving the final state.
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside the final state");
`endif

endmodule

`default_nettype wire
